FILE: design/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Types and codes shared by the line cache and prefetcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_pkg;

	localparam int ADDR_W = 48;
	localparam int LINE_W = 44;
	localparam int TICK_W = 48;
	localparam int CNT_W  = 3;
	localparam int OUTS_W = 8;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STRIDE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STREAM = 2'd3;

	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_INC    = 2'd1;
	localparam logic [1:0] OP_DEC    = 2'd2;
	localparam logic [1:0] OP_DECINC = 2'd3;

	localparam logic [2:0] WR_HIT         = 3'd0;
	localparam logic [2:0] WR_SB_FOUND    = 3'd1;
	localparam logic [2:0] WR_FILL_DEMAND = 3'd2;
	localparam logic [2:0] WR_FILL_SB     = 3'd3;
	localparam logic [2:0] WR_FILL_PF     = 3'd4;

	typedef struct packed {
		logic [LINE_W-1:0] tag;
		logic              valid;
		logic              pf;
		logic              used;
		logic [TICK_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic       accept;
		logic       clr_step;
		logic       scan_start;
		logic       scan_tgt;
		logic       wr_en;
		logic [2:0] wr_kind;
		logic [1:0] out_op;
		logic       inc_issued;
		logic       inc_wasted;
		logic       set_hit;
		logic       set_sb;
		logic       set_useful;
		logic       tgt_next;
		logic       stride_upd;
		logic       sb_advance;
		logic       refill_step;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic scan_busy;
		logic m_found;
		logic m_pf;
		logic m_used;
		logic evict_waste;
		logic sb_match;
		logic stride_fire;
		logic refill_valid;
		logic refill_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: design/lcp_ram.sv
// ----------------------------------------------------------------------------
// lcp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/lcp_ctrl.sv
// ----------------------------------------------------------------------------
// lcp_ctrl
// Sequencer: steps each access through lookup, fill, prefetch and report.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               ready,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lcp_pkg::MODE_W-1:0]    cfg_wr_data,
	input  wire lcp_pkg::status_t              st,
	output lcp_pkg::cmd_t                      cmd
);

	localparam logic [3:0] ST_CLR      = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_DIV      = 4'd2;
	localparam logic [3:0] ST_SCAN1    = 4'd3;
	localparam logic [3:0] ST_EVAL1    = 4'd4;
	localparam logic [3:0] ST_SB_DEC   = 4'd5;
	localparam logic [3:0] ST_SB_INC   = 4'd6;
	localparam logic [3:0] ST_PF_START = 4'd7;
	localparam logic [3:0] ST_PF_SCAN  = 4'd8;
	localparam logic [3:0] ST_EVAL2    = 4'd9;
	localparam logic [3:0] ST_PF_INC   = 4'd10;
	localparam logic [3:0] ST_REFILL   = 4'd11;
	localparam logic [3:0] ST_DONE     = 4'd12;

	logic [3:0]                   state_q, state_d;
	logic [lcp_pkg::MODE_W-1:0]   mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			mode_q  <= lcp_pkg::MODE_NONE;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
		end
	end

	assign ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!st.div_busy) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN1;
				end
			end
			ST_SCAN1: begin
				if (!st.scan_busy) state_d = ST_EVAL1;
			end
			ST_EVAL1: begin
				if (mode_q == lcp_pkg::MODE_STREAM && st.sb_match) begin
					cmd.set_hit    = 1'b1;
					cmd.set_sb     = 1'b1;
					cmd.set_useful = 1'b1;
					cmd.wr_en      = 1'b1;
					if (st.m_found) begin
						cmd.wr_kind = lcp_pkg::WR_SB_FOUND;
					end else begin
						cmd.wr_kind    = lcp_pkg::WR_FILL_SB;
						cmd.inc_issued = 1'b1;
						if (st.evict_waste) begin
							cmd.inc_wasted = 1'b1;
							cmd.out_op     = lcp_pkg::OP_DEC;
						end
					end
					state_d = ST_SB_DEC;
				end else if (st.m_found) begin
					cmd.set_hit = 1'b1;
					cmd.wr_en   = 1'b1;
					cmd.wr_kind = lcp_pkg::WR_HIT;
					if (st.m_pf && !st.m_used) begin
						cmd.set_useful = 1'b1;
						cmd.out_op     = lcp_pkg::OP_DEC;
					end
					state_d = ST_DONE;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_kind = lcp_pkg::WR_FILL_DEMAND;
					if (st.evict_waste) begin
						cmd.inc_wasted = 1'b1;
						cmd.out_op     = lcp_pkg::OP_DEC;
					end
					unique case (mode_q)
						lcp_pkg::MODE_NEXT: begin
							cmd.tgt_next = 1'b1;
							state_d      = ST_PF_START;
						end
						lcp_pkg::MODE_STRIDE: begin
							cmd.stride_upd = 1'b1;
							state_d        = st.stride_fire ? ST_PF_START : ST_DONE;
						end
						lcp_pkg::MODE_STREAM: state_d = ST_REFILL;
						default:              state_d = ST_DONE;
					endcase
				end
			end
			ST_SB_DEC: begin
				cmd.out_op = lcp_pkg::OP_DEC;
				state_d    = ST_SB_INC;
			end
			ST_SB_INC: begin
				cmd.out_op     = lcp_pkg::OP_INC;
				cmd.inc_issued = 1'b1;
				cmd.sb_advance = 1'b1;
				state_d        = ST_DONE;
			end
			ST_PF_START: begin
				cmd.scan_start = 1'b1;
				cmd.scan_tgt   = 1'b1;
				state_d        = ST_PF_SCAN;
			end
			ST_PF_SCAN: begin
				if (!st.scan_busy) state_d = ST_EVAL2;
			end
			ST_EVAL2: begin
				if (!st.m_found) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_kind    = lcp_pkg::WR_FILL_PF;
					cmd.inc_issued = 1'b1;
					if (st.evict_waste) begin
						cmd.inc_wasted = 1'b1;
						cmd.out_op     = lcp_pkg::OP_DEC;
					end
					state_d = ST_PF_INC;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PF_INC: begin
				cmd.out_op = lcp_pkg::OP_INC;
				state_d    = ST_DONE;
			end
			ST_REFILL: begin
				cmd.refill_step = 1'b1;
				cmd.inc_issued  = 1'b1;
				if (st.refill_valid) begin
					cmd.inc_wasted = 1'b1;
					cmd.out_op     = lcp_pkg::OP_DECINC;
				end else begin
					cmd.out_op = lcp_pkg::OP_INC;
				end
				if (st.refill_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/lcp_dp.sv
// ----------------------------------------------------------------------------
// lcp_dp
// Datapath: line address unit, tag store scan, prefetcher state and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_dp #(
	parameter int CACHE_LINES  = 64,
	parameter int STREAM_DEPTH = 4,
	parameter int LINE_BYTES   = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcp_pkg::cmd_t                 cmd,
	output lcp_pkg::status_t                   st,
	input  wire logic [lcp_pkg::ADDR_W-1:0]    byte_address,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic                               hit,
	output logic                               from_stream_buffer,
	output logic                               prefetch_useful,
	output logic [lcp_pkg::CNT_W-1:0]          prefetches_issued,
	output logic [lcp_pkg::CNT_W-1:0]          prefetches_wasted,
	output logic [lcp_pkg::OUTS_W-1:0]         outstanding
);

	localparam int IW  = $clog2(CACHE_LINES);
	localparam int SIW = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
	localparam int LW  = lcp_pkg::LINE_W;
	localparam int EW  = $bits(lcp_pkg::entry_t);
	localparam bit IS_POW2 = ((LINE_BYTES & (LINE_BYTES - 1)) == 0);

	// ---------------- line address ----------------
	logic [LW-1:0] line_q;
	logic          div_busy;

	generate
		if (IS_POW2) begin : g_shift
			localparam int SH = $clog2(LINE_BYTES);
			logic [lcp_pkg::ADDR_W-1:0] shifted;
			assign shifted  = byte_address >> SH;
			assign div_busy = 1'b0;
			always_ff @(posedge clk) begin
				if (cmd.accept) line_q <= shifted[LW-1:0];
			end
		end else begin : g_div
			// The quotient is the address times ceil(2^(48 + L) / LINE_BYTES),
			// shifted down by 48 + L, where 2^L is at least the line size; this is
			// exact for every 48-bit address. The product is built from four
			// partial products of 24 by 25 bits, one a cycle.
			localparam int L  = $clog2(LINE_BYTES);
			localparam int HW = lcp_pkg::ADDR_W / 2;
			localparam int MW = lcp_pkg::ADDR_W + 1;
			localparam int PW = 2 * lcp_pkg::ADDR_W + 1;
			localparam logic [63:0] RECIP =
				((64'd1 << (lcp_pkg::ADDR_W + L)) + 64'(LINE_BYTES) - 64'd1) /
				64'(LINE_BYTES);
			localparam logic [MW-1:0] MULT = RECIP[MW-1:0];
			logic [lcp_pkg::ADDR_W-1:0] x_q;
			logic [PW-1:0]              acc_q, acc_d, pp_ext, quo;
			logic [HW-1:0]              a_part;
			logic [HW:0]                m_part;
			logic [2*HW:0]              pp;
			logic [1:0]                 step_q;
			logic                       busy_q;
			assign a_part   = step_q[1] ? x_q[2*HW-1:HW] : x_q[HW-1:0];
			assign m_part   = step_q[0] ? MULT[MW-1:HW] : {1'b0, MULT[HW-1:0]};
			assign pp       = a_part * m_part;
			always_comb begin
				unique case (step_q)
					2'd0:    pp_ext = PW'(pp);
					2'd3:    pp_ext = PW'(pp) << (2 * HW);
					default: pp_ext = PW'(pp) << HW;
				endcase
			end
			assign acc_d    = acc_q + pp_ext;
			assign quo      = acc_d >> (lcp_pkg::ADDR_W + L);
			assign div_busy = busy_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
				end else if (cmd.accept) begin
					busy_q <= 1'b1;
				end else if (busy_q && step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
			always_ff @(posedge clk) begin
				if (cmd.accept) begin
					x_q    <= byte_address;
					acc_q  <= '0;
					step_q <= '0;
				end else if (busy_q) begin
					acc_q  <= acc_d;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						line_q <= quo[LW-1:0];
					end
				end
			end
		end
	endgenerate

	// ---------------- access tick and target ----------------
	logic [lcp_pkg::TICK_W-1:0] tick_q;
	logic [LW-1:0]              tgt_q, prev_line_q, prev_stride_q, stride_d;
	logic                       prev_seen_q;

	assign stride_d       = line_q - prev_line_q;
	assign st.stride_fire = prev_seen_q && (stride_d == prev_stride_q) && (stride_d != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			prev_line_q   <= '0;
			prev_stride_q <= '0;
			prev_seen_q   <= 1'b0;
		end else begin
			if (cmd.accept) tick_q <= tick_q + 1'b1;
			if (cmd.stride_upd) begin
				if (prev_seen_q) prev_stride_q <= stride_d;
				prev_line_q <= line_q;
				prev_seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_next) begin
			tgt_q <= line_q + LW'(1);
		end else if (cmd.stride_upd) begin
			tgt_q <= line_q + stride_d;
		end
	end

	// ---------------- tag store ----------------
	lcp_pkg::entry_t ram_rdata, ram_wdata, wr_entry, clr_entry;
	logic [EW-1:0]   rdata_raw;
	logic [IW-1:0]   ram_waddr, scan_cnt_q, clr_q, rd_idx_s1, wr_idx;
	logic            ram_we;

	lcp_ram #(.WIDTH(EW), .DEPTH(CACHE_LINES)) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_cnt_q),
		.rdata (rdata_raw)
	);
	assign ram_rdata = lcp_pkg::entry_t'(rdata_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign st.clr_last = (clr_q == IW'(CACHE_LINES - 1));

	// ---------------- scan over all lines ----------------
	logic          issue_q, rd_pend_s1, scan_tgt_q;
	logic          m_found_q, m_pf_q, m_used_q, inv_found_q, min_pf_q, min_used_q;
	logic [IW-1:0] m_idx_q, inv_idx_q, min_idx_q, victim;
	logic [lcp_pkg::TICK_W-1:0] min_stamp_q;
	logic [LW-1:0] key;

	assign key          = scan_tgt_q ? tgt_q : line_q;
	assign st.scan_busy = issue_q | rd_pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= issue_q;
			if (cmd.scan_start) begin
				issue_q <= 1'b1;
			end else if (issue_q && scan_cnt_q == IW'(CACHE_LINES - 1)) begin
				issue_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_cnt_q  <= '0;
			scan_tgt_q  <= cmd.scan_tgt;
			m_found_q   <= 1'b0;
			inv_found_q <= 1'b0;
		end else begin
			if (issue_q && scan_cnt_q != IW'(CACHE_LINES - 1)) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (rd_pend_s1) begin
				if (ram_rdata.valid && ram_rdata.tag == key && !m_found_q) begin
					m_found_q <= 1'b1;
					m_idx_q   <= rd_idx_s1;
					m_pf_q    <= ram_rdata.pf;
					m_used_q  <= ram_rdata.used;
				end
				if (!ram_rdata.valid && !inv_found_q) begin
					inv_found_q <= 1'b1;
					inv_idx_q   <= rd_idx_s1;
				end
				if (rd_idx_s1 == '0 || ram_rdata.stamp < min_stamp_q) begin
					min_stamp_q <= ram_rdata.stamp;
					min_idx_q   <= rd_idx_s1;
					min_pf_q    <= ram_rdata.pf;
					min_used_q  <= ram_rdata.used;
				end
			end
		end
		rd_idx_s1 <= scan_cnt_q;
	end

	assign victim         = inv_found_q ? inv_idx_q : min_idx_q;
	assign st.m_found     = m_found_q;
	assign st.m_pf        = m_pf_q;
	assign st.m_used      = m_used_q;
	assign st.evict_waste = !inv_found_q && min_pf_q && !min_used_q;

	always_comb begin
		wr_entry.valid = 1'b1;
		wr_entry.stamp = tick_q;
		wr_entry.tag   = line_q;
		wr_idx         = victim;
		unique case (cmd.wr_kind)
			lcp_pkg::WR_HIT: begin
				wr_idx        = m_idx_q;
				wr_entry.pf   = m_pf_q;
				wr_entry.used = m_used_q | m_pf_q;
			end
			lcp_pkg::WR_SB_FOUND: begin
				wr_idx        = m_idx_q;
				wr_entry.pf   = m_pf_q;
				wr_entry.used = 1'b1;
			end
			lcp_pkg::WR_FILL_SB: begin
				wr_entry.pf   = 1'b1;
				wr_entry.used = 1'b1;
			end
			lcp_pkg::WR_FILL_PF: begin
				wr_entry.tag  = tgt_q;
				wr_entry.pf   = 1'b1;
				wr_entry.used = 1'b0;
			end
			default: begin
				wr_entry.pf   = 1'b0;
				wr_entry.used = 1'b0;
			end
		endcase
	end

	assign clr_entry = '{tag: '1, valid: 1'b0, pf: 1'b0, used: 1'b0, stamp: '0};
	assign ram_we    = cmd.clr_step | cmd.wr_en;
	assign ram_waddr = cmd.clr_step ? clr_q : wr_idx;
	assign ram_wdata = cmd.clr_step ? clr_entry : wr_entry;

	// ---------------- stream buffer ----------------
	logic [LW-1:0]           sb_entry_q [STREAM_DEPTH];
	logic [STREAM_DEPTH-1:0] sb_valid_q;
	logic [LW-1:0]           sb_next_q;
	logic [SIW-1:0]          sb_idx, refill_q;
	logic                    sb_hit;

	always_comb begin
		sb_hit = 1'b0;
		sb_idx = '0;
		for (int i = STREAM_DEPTH - 1; i >= 0; i--) begin
			if (sb_valid_q[i] && sb_entry_q[i] == line_q) begin
				sb_hit = 1'b1;
				sb_idx = SIW'(i);
			end
		end
	end
	assign st.sb_match     = sb_hit;
	assign st.refill_valid = sb_valid_q[refill_q];
	assign st.refill_last  = (refill_q == SIW'(STREAM_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_valid_q <= '0;
			sb_next_q  <= '1;
			refill_q   <= '0;
			for (int i = 0; i < STREAM_DEPTH; i++) sb_entry_q[i] <= '0;
		end else begin
			if (cmd.accept) refill_q <= '0;
			if (cmd.sb_advance) begin
				sb_entry_q[sb_idx] <= sb_next_q;
				sb_next_q          <= sb_next_q + LW'(1);
			end
			if (cmd.refill_step) begin
				sb_entry_q[refill_q] <= line_q + LW'(1) + LW'(refill_q);
				sb_valid_q[refill_q] <= 1'b1;
				refill_q             <= refill_q + 1'b1;
				if (st.refill_last) sb_next_q <= line_q + LW'(STREAM_DEPTH + 1);
			end
		end
	end

	// ---------------- counters and result ----------------
	logic [lcp_pkg::OUTS_W-1:0] outs_q;
	logic [lcp_pkg::CNT_W-1:0]  issued_q, wasted_q;
	logic                       r_hit_q, r_sb_q, r_useful_q, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outs_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.out_op)
				lcp_pkg::OP_INC:    if (outs_q != '1) outs_q <= outs_q + 1'b1;
				lcp_pkg::OP_DEC:    if (outs_q != '0) outs_q <= outs_q - 1'b1;
				// Decrement then increment: only an empty count moves.
				lcp_pkg::OP_DECINC: if (outs_q == '0) outs_q <= 8'd1;
				default: ;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			issued_q   <= '0;
			wasted_q   <= '0;
			r_hit_q    <= 1'b0;
			r_sb_q     <= 1'b0;
			r_useful_q <= 1'b0;
		end else begin
			if (cmd.inc_issued) issued_q <= issued_q + 1'b1;
			if (cmd.inc_wasted) wasted_q <= wasted_q + 1'b1;
			if (cmd.set_hit)    r_hit_q    <= 1'b1;
			if (cmd.set_sb)     r_sb_q     <= 1'b1;
			if (cmd.set_useful) r_useful_q <= 1'b1;
		end
		if (cmd.out_load) begin
			hit                <= r_hit_q;
			from_stream_buffer <= r_sb_q;
			prefetch_useful    <= r_useful_q;
			prefetches_issued  <= issued_q;
			prefetches_wasted  <= wasted_q;
			outstanding        <= outs_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign st.out_free = !out_valid_q || !out_stall;
	assign st.div_busy = div_busy;

endmodule

`default_nettype wire

FILE: design/lru_cache_with_prefetchers_unit.sv
// ----------------------------------------------------------------------------
// lru_cache_with_prefetchers_unit
// Fully associative LRU line cache with next-line, stride and stream prefetch.
// ----------------------------------------------------------------------------
// Each input word is a byte address; each output word reports hit status,
// prefetch counts and the outstanding-prefetch count for that access.
// Input and output use valid/stall; one output word per input word, in order.
// The tag store is one RAM scanned one line a cycle. An access runs one
// lookup pass, or two when a next-line or stride prefetch is looked up, plus
// control states, and a stream refill steps through the STREAM_DEPTH buffer
// entries in turn. A line size that is not a power of two adds a reciprocal
// multiplication before the lookup. The result sits in an output register;
// the block takes the next address while it waits and only holds the
// finished access if the register is full. After reset a clearing pass over
// all CACHE_LINES entries invalidates the tag store and in_stall stays high;
// mode writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_with_prefetchers_unit #(
	parameter int CACHE_LINES  = 64,
	parameter int STREAM_DEPTH = 4,
	parameter int LINE_BYTES   = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [47:0] byte_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit,
	output logic             from_stream_buffer,
	output logic             prefetch_useful,
	output logic [2:0]       prefetches_issued,
	output logic [2:0]       prefetches_wasted,
	output logic [7:0]       outstanding,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data
);

	lcp_pkg::cmd_t    cmd;
	lcp_pkg::status_t st;
	logic             ready;

	assign in_stall = !ready;

	lcp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.ready       (ready),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.st          (st),
		.cmd         (cmd)
	);

	lcp_dp #(
		.CACHE_LINES  (CACHE_LINES),
		.STREAM_DEPTH (STREAM_DEPTH),
		.LINE_BYTES   (LINE_BYTES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.byte_address       (byte_address),
		.out_stall          (out_stall),
		.out_valid          (out_valid),
		.hit                (hit),
		.from_stream_buffer (from_stream_buffer),
		.prefetch_useful    (prefetch_useful),
		.prefetches_issued  (prefetches_issued),
		.prefetches_wasted  (prefetches_wasted),
		.outstanding        (outstanding)
	);

endmodule

`default_nettype wire

FILE: design/lcp_checker.sv
// ----------------------------------------------------------------------------
// lcp_checker
// Port-level checks of the result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       hit,
	input wire logic       from_stream_buffer,
	input wire logic       prefetch_useful,
	input wire logic [2:0] prefetches_issued,
	input wire logic [2:0] prefetches_wasted
);

	// A stalled word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// A stream buffer match is always a hit and a first use.
	a_sb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && from_stream_buffer |-> hit && prefetch_useful)
		else $error("stream match without hit or use");

	// Only a hit can use a prefetched line.
	a_useful: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prefetch_useful |-> hit)
		else $error("useful prefetch on a miss");

	// A plain cache hit neither issues nor discards prefetches.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit && !from_stream_buffer |->
		prefetches_issued == 3'd0 && prefetches_wasted == 3'd0)
		else $error("prefetch activity on a cache hit");

endmodule

bind lru_cache_with_prefetchers_unit lcp_checker u_lcp_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Line cache prefetcher regression
// Drives byte addresses through the line cache under every prefetch mode and
// compares each result word with an in-bench model of the cache and the
// next-line, stride and stream-buffer prefetchers, or for directed words with a given result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NLINES    = 64;
	localparam int SB_DEPTH  = 4;
	localparam int LBYTES    = 64;
	localparam int MAX_CYCLES = 1200000;
	localparam int LW = lcp_pkg::LINE_W;
	localparam int TW = lcp_pkg::TICK_W;
	localparam int CW = lcp_pkg::CNT_W;
	localparam int OW = lcp_pkg::OUTS_W;
	localparam int MW = lcp_pkg::MODE_W;

	typedef struct packed {
		logic          hit;
		logic          sb;
		logic          useful;
		logic [CW-1:0] issued;
		logic [CW-1:0] wasted;
		logic [OW-1:0] outs;
	} access_res_t;

	typedef struct {
		logic [47:0] addr;
		bit          known;
		access_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [47:0] byte_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit, from_stream_buffer, prefetch_useful;
	logic [2:0] prefetches_issued, prefetches_wasted;
	logic [7:0] outstanding;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = '0;

	always #4 clk = ~clk;

	lru_cache_with_prefetchers_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .byte_address(byte_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .from_stream_buffer(from_stream_buffer),
		.prefetch_useful(prefetch_useful), .prefetches_issued(prefetches_issued),
		.prefetches_wasted(prefetches_wasted), .outstanding(outstanding),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// Shadow copy of the cache and prefetcher state.
	logic [LW-1:0] c_tag [NLINES];
	bit            c_valid [NLINES];
	bit            c_pf [NLINES];
	bit            c_used [NLINES];
	logic [TW-1:0] c_stamp [NLINES];
	logic [TW-1:0] tick;
	int unsigned   outs_cnt;
	logic [LW-1:0] last_miss;
	bit            last_miss_seen;
	logic [LW-1:0] miss_stride;
	logic [LW-1:0] sb_line [SB_DEPTH];
	bit            sb_valid [SB_DEPTH];
	logic [LW-1:0] sb_next;
	logic [MW-1:0] mode;
	int unsigned   n_issued, n_wasted;

	access_res_t expected_q[$];
	int errors = 0;
	int accepted = 0;
	int received = 0;
	int cycles = 0;
	int in_idle_pct = 17;
	int out_idle_pct = 61;
	bit hold_off = 1'b0;
	int hits_seen = 0;
	int sb_seen = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch on word %0d: %s got %0d expected %0d", received, what, got, want);
		errors++;
	endtask

	function automatic void outs_up();
		if (outs_cnt < 255) outs_cnt++;
	endfunction

	function automatic void outs_down();
		if (outs_cnt > 0) outs_cnt--;
	endfunction

	function automatic int find_line(logic [LW-1:0] ln);
		for (int i = 0; i < NLINES; i++)
			if (c_valid[i] && c_tag[i] == ln) return i;
		return -1;
	endfunction

	function automatic int pick_victim();
		int v;
		v = 0;
		for (int i = 0; i < NLINES; i++)
			if (!c_valid[i]) return i;
		for (int i = 1; i < NLINES; i++)
			if (c_stamp[i] < c_stamp[v]) v = i;
		if (c_pf[v] && !c_used[v]) begin
			n_wasted++;
			outs_down();
		end
		return v;
	endfunction

	function automatic void fill_line(logic [LW-1:0] ln, bit pf);
		int s;
		if (find_line(ln) >= 0) return;
		s = pick_victim();
		c_valid[s] = 1'b1;
		c_tag[s] = ln;
		c_pf[s] = pf;
		c_used[s] = 1'b0;
		c_stamp[s] = tick;
		if (pf) n_issued++;
	endfunction

	function automatic void prefetch_line(logic [LW-1:0] ln);
		if (find_line(ln) < 0) begin
			fill_line(ln, 1'b1);
			outs_up();
		end
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < NLINES; i++) begin
			c_tag[i] = '1;
			c_valid[i] = 0;
			c_pf[i] = 0;
			c_used[i] = 0;
			c_stamp[i] = '0;
		end
		for (int i = 0; i < SB_DEPTH; i++) begin
			sb_line[i] = '0;
			sb_valid[i] = 0;
		end
		tick = '0;
		outs_cnt = 0;
		last_miss = '0;
		last_miss_seen = 0;
		miss_stride = '0;
		sb_next = '1;
		mode = lcp_pkg::MODE_NONE;
	endfunction

	function automatic access_res_t predict_access(logic [47:0] addr);
		access_res_t r;
		logic [LW-1:0] ln, d;
		int s;
		bit matched;
		r = '0;
		matched = 0;
		ln = LW'(addr / LBYTES);
		n_issued = 0;
		n_wasted = 0;
		tick = tick + 1'b1;
		if (mode == lcp_pkg::MODE_STREAM) begin
			for (int i = 0; i < SB_DEPTH && !matched; i++) begin
				if (sb_valid[i] && sb_line[i] == ln) begin
					matched = 1;
					fill_line(ln, 1'b1);
					s = find_line(ln);
					if (s >= 0) begin
						c_used[s] = 1'b1;
						c_stamp[s] = tick;
					end
					outs_down();
					sb_line[i] = sb_next;
					sb_next = sb_next + 1'b1;
					outs_up();
					n_issued++;
				end
			end
		end
		if (matched) begin
			r.hit = 1;
			r.sb = 1;
			r.useful = 1;
		end else begin
			s = find_line(ln);
			if (s >= 0) begin
				r.hit = 1;
				if (c_pf[s] && !c_used[s]) begin
					c_used[s] = 1'b1;
					r.useful = 1;
					outs_down();
				end
				c_stamp[s] = tick;
			end else begin
				fill_line(ln, 1'b0);
				case (mode)
					lcp_pkg::MODE_NEXT: prefetch_line(ln + 1'b1);
					lcp_pkg::MODE_STRIDE: begin
						if (last_miss_seen) begin
							d = ln - last_miss;
							if (d == miss_stride && d != 0) prefetch_line(ln + d);
							miss_stride = d;
						end
						last_miss = ln;
						last_miss_seen = 1;
					end
					lcp_pkg::MODE_STREAM: begin
						for (int i = 0; i < SB_DEPTH; i++) begin
							if (sb_valid[i]) begin
								n_wasted++;
								outs_down();
							end
							sb_line[i] = ln + LW'(1 + i);
							sb_valid[i] = 1;
							n_issued++;
							outs_up();
						end
						sb_next = ln + LW'(1 + SB_DEPTH);
					end
					default: ;
				endcase
			end
		end
		r.issued = n_issued[CW-1:0];
		r.wasted = n_wasted[CW-1:0];
		r.outs = outs_cnt[OW-1:0];
		return r;
	endfunction

	// Valid stays high from one word to the next unless the sender idles.
	task automatic send_address(logic [47:0] addr, bit known, access_res_t want);
		access_res_t p;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_address <= addr;
		p = predict_access(addr);
		expected_q.push_back(known ? want : p);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		accepted++;
		@(negedge clk);
	endtask

	// Waits until every word has come back, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (2 * NLINES + 20) @(negedge clk);
	endtask

	task automatic set_mode(logic [MW-1:0] m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mode = m;
	endtask

	function automatic logic [47:0] rand_addr();
		return 48'({$urandom(), $urandom()});
	endfunction

	// Addresses come mostly from a small pool of lines so that hits and evictions occur.
	task automatic random_phase(int n);
		logic [47:0] base, a;
		logic [LW-1:0] st;
		int k;
		k = 0;
		while (k < n) begin
			base = {2'($urandom_range(3)), 46'h0} | 48'($urandom_range(200)) * LBYTES;
			case ($urandom_range(4))
				0: begin
					st = LW'($urandom_range(1, 5));
					for (int j = 0; j < 8; j++) begin
						a = base + 48'(j) * 48'(st) * LBYTES + 48'($urandom_range(63));
						send_address(a, 0, '0);
						k++;
					end
				end
				1: begin
					for (int j = 0; j < 10; j++) begin
						send_address(base + 48'(j) * LBYTES + 48'($urandom_range(63)), 0, '0);
						k++;
					end
				end
				2: begin
					send_address(rand_addr(), 0, '0);
					k++;
				end
				default: begin
					send_address(base + 48'($urandom_range(63)), 0, '0);
					k++;
				end
			endcase
		end
	endtask

	// Response checker.
	always @(posedge clk) begin
		access_res_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{hit, from_stream_buffer, prefetch_useful, prefetches_issued,
				prefetches_wasted, outstanding};
			if (expected_q.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.hit !== want.hit) report("hit", got.hit, want.hit);
				if (got.sb !== want.sb) report("from_stream_buffer", got.sb, want.sb);
				if (got.useful !== want.useful) report("prefetch_useful", got.useful, want.useful);
				if (got.issued !== want.issued) report("issued", got.issued, want.issued);
				if (got.wasted !== want.wasted) report("wasted", got.wasted, want.wasted);
				if (got.outs !== want.outs) report("outstanding", got.outs, want.outs);
				hits_seen += got.hit;
				sb_seen += got.sb;
			end
			received++;
		end
	end

	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	stim_row_t dir_rows[$];

	initial begin
		access_res_t e;
		clear_model();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// After reset the first words miss, a repeat of line zero hits, and nothing is prefetched in mode none.
		e = '0;
		e.outs = '0;
		dir_rows.push_back('{48'h0, 1, e});
		dir_rows.push_back('{48'hFFFF_FFFF_FFFF, 1, e});
		e.hit = 1;
		dir_rows.push_back('{48'h3F, 1, e});
		dir_rows.push_back('{48'hAAAA_AAAA_AAAA, 0, '0});
		dir_rows.push_back('{48'h5555_5555_5555, 0, '0});
		foreach (dir_rows[i]) send_address(dir_rows[i].addr, dir_rows[i].known, dir_rows[i].res);

		// Next line: the top line, then a miss followed by a hit on its prefetched next line.
		set_mode(lcp_pkg::MODE_NEXT);
		send_address(48'hFFFF_FFFF_FFC0, 0, '0);
		send_address(48'h1000, 0, '0);
		send_address(48'h1040, 0, '0);
		// Stride: equal nonzero strides, including a wrapping negative one.
		set_mode(lcp_pkg::MODE_STRIDE);
		for (int j = 0; j < 4; j++) send_address(48'h20000 + 48'(j) * 3 * LBYTES, 0, '0);
		for (int j = 0; j < 3; j++) send_address(48'h40000 - 48'(j) * 2 * LBYTES, 0, '0);
		// Stream buffer: refill, matches, a plain hit, and a refill over valid entries.
		set_mode(lcp_pkg::MODE_STREAM);
		send_address(48'h80000, 0, '0);
		send_address(48'h80040, 0, '0);
		send_address(48'h80080, 0, '0);
		send_address(48'h80000, 0, '0);
		send_address(48'h100000, 0, '0);

		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 61 : 0;
			out_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 17 : 0;
			for (int m = 0; m < 4; m++) begin
				set_mode(m[MW-1:0]);
				random_phase(90);
			end
		end

		// Long receiver hold-off while the sender keeps offering words.
		set_mode(lcp_pkg::MODE_STREAM);
		hold_off = 1'b1;
		fork
			begin
				repeat (600) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				random_phase(20);
				drain();
			end
		join
		set_mode(lcp_pkg::MODE_NONE);
		drain();

		$display("%0d addresses checked over all four prefetch modes,", accepted);
		$display("with %0d hits, %0d of them from the stream buffer", hits_seen, sb_seen);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
